FILE: rtl/sfcs_pkg.sv
// Package for the SPI flash command sequencer: bus action, request and
// operation codes, flash opcodes and the result word type.
// No dependencies.
package sfcs_pkg;

    localparam int MAX_RESULTS = 12;
    localparam int RES_IDX_W = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        ACT_LOW    = 3'd0,
        ACT_SEND   = 3'd1,
        ACT_RECV   = 3'd2,
        ACT_HIGH   = 3'd3,
        ACT_REPORT = 3'd4
    } act_t;

    typedef logic [2:0] req_t;
    localparam req_t REQ_ID      = 3'd0;
    localparam req_t REQ_READ    = 3'd1;
    localparam req_t REQ_ERASE   = 3'd2;
    localparam req_t REQ_WRITE   = 3'd3;
    localparam req_t REQ_DATA    = 3'd4;
    localparam req_t REQ_BYTE_IN = 3'd5;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ID    = 2'd0;
    localparam kind_t KIND_READ  = 2'd1;
    localparam kind_t KIND_ERASE = 2'd2;
    localparam kind_t KIND_WRITE = 2'd3;

    localparam logic [7:0] EXPECTED_ID = 8'h9d;
    localparam logic [7:0] OP_STATUS   = 8'h05;
    localparam logic [7:0] OP_READ     = 8'h03;
    localparam logic [7:0] OP_ERASE    = 8'hd7;
    localparam logic [7:0] OP_PROGRAM  = 8'h02;
    localparam logic [7:0] OP_WREN     = 8'h06;
    localparam logic [7:0] OP_ID       = 8'h9f;

    localparam logic REG_BUSY_BIT = 1'b0;

    typedef struct packed {
        act_t       act;
        logic [7:0] val;
        logic       st;
        logic       done;
    } res_t;

    function automatic res_t mk(act_t a, logic [7:0] v, logic s, logic d);
        res_t r;
        r.act  = a;
        r.val  = v;
        r.st   = s;
        r.done = d;
        return r;
    endfunction

endpackage

FILE: rtl/spi_flash_command_sequencer.sv
// An accepted word is registered, then expanded into up to twelve bus actions that
// leave one word per cycle while m_tready is high. Expansion waits until the result
// buffer is empty or its last action is taken. The input register takes the next word
// while actions drain. Reset clears the phase and state and sets the busy bit index to
// one. Depends on sfcs_pkg. Sector and page sizes must be powers of two; the module
// does not enforce it.
module spi_flash_command_sequencer #(
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096,
    parameter int ADDRESS_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // base_addr[23:0], byte_count[48:24], data_byte[56:49], zero fill
    input  logic [63:0] s_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_value[7:0], op_status[8], op_done[9], zero fill
    output logic [15:0] m_tdata,
    // bus_action[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = ADDRESS_BITS;
    localparam int SB = $clog2(SECTOR_BYTES);
    localparam int PB = $clog2(PAGE_BYTES);
    localparam logic [24:0] SPACE = 25'(64'(1) << AW);
    localparam logic [AW-1:0] SECTOR_MASK = AW'((64'(1) << SB) - 64'(1));
    localparam logic [AW-1:0] PAGE_MASK = AW'((64'(1) << PB) - 64'(1));
    localparam logic [AW-1:0] SECTOR_STEP = AW'(64'(1) << SB);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ID,
        PH_READ,
        PH_POLL,
        PH_DATA
    } phase_t;

    phase_t                           phase_reg, phase_next;
    sfcs_pkg::kind_t                  kind_reg, kind_next;
    logic [AW-1:0]                    cur_addr_reg, cur_addr_next;
    logic [24:0]                      remain_reg, remain_next;
    logic [AW-1:0]                    end_addr_reg, end_addr_next;
    logic                             poll_after_reg, poll_after_next;
    logic [2:0]                       busy_bit_reg, busy_bit_next;
    logic                             in_valid_reg, in_valid_next;
    sfcs_pkg::req_t                   in_req_reg;
    logic [23:0]                      in_addr_reg;
    logic [24:0]                      in_cnt_reg;
    logic [7:0]                       in_byte_reg;
    logic [sfcs_pkg::RES_CNT_W-1:0]   rem_reg, rem_next;
    sfcs_pkg::res_t                   list_reg [sfcs_pkg::MAX_RESULTS];
    sfcs_pkg::res_t                   list_next [sfcs_pkg::MAX_RESULTS];

    logic                             take;
    logic                             proceed;
    logic                             in_take;
    logic [sfcs_pkg::RES_CNT_W-1:0]   n;
    logic [AW-1:0]                    addr_m;
    logic [24:0]                      avail;
    logic [24:0]                      cnt_c;
    logic [24:0]                      last_byte;
    logic [AW-1:0]                    cur_inc;
    logic [23:0]                      addr24;
    logic [24:0]                      rem_after;
    logic                             busy;
    logic                             cfg_write;

    assign take      = m_tvalid && m_tready;
    assign proceed   = in_valid_reg && ((rem_reg == '0) ||
                       ((rem_reg == sfcs_pkg::RES_CNT_W'(1)) && m_tready));
    assign s_tready  = !in_valid_reg || proceed;
    assign in_take   = s_tvalid && s_tready;

    assign addr_m    = in_addr_reg[AW-1:0];
    assign avail     = SPACE - 25'(addr_m);
    assign cnt_c     = (in_cnt_reg > avail) ? avail : in_cnt_reg;
    assign last_byte = 25'(addr_m) + cnt_c - 25'd1;
    assign cur_inc   = cur_addr_reg + AW'(1);
    assign addr24    = 24'(cur_addr_reg);
    assign rem_after = (remain_reg != '0) ? remain_reg - 25'd1 : '0;
    assign busy      = in_byte_reg[busy_bit_reg];

    assign m_tvalid  = (rem_reg != '0);
    assign m_tlast   = (rem_reg == sfcs_pkg::RES_CNT_W'(1));
    assign m_tuser   = list_reg[0].act;
    assign m_tdata   = {6'd0, list_reg[0].done, list_reg[0].st, list_reg[0].val};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == sfcs_pkg::REG_BUSY_BIT) ? 32'(busy_bit_reg) : 32'd0;

    always_comb
    begin
        busy_bit_next = busy_bit_reg;
        if (cfg_write && (paddr[2] == sfcs_pkg::REG_BUSY_BIT))
        begin
            busy_bit_next = pwdata[2:0];
        end
    end

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        cur_addr_next   = cur_addr_reg;
        remain_next     = remain_reg;
        end_addr_next   = end_addr_reg;
        poll_after_next = poll_after_reg;
        rem_next        = rem_reg;
        n               = '0;
        for (int i = 0; i < sfcs_pkg::MAX_RESULTS; i++)
        begin
            list_next[i] = list_reg[i];
        end

        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (proceed)
        begin
            in_valid_next = 1'b0;
        end

        if (take)
        begin
            for (int i = 0; i < sfcs_pkg::MAX_RESULTS - 1; i++)
            begin
                list_next[i] = list_reg[i+1];
            end
            list_next[sfcs_pkg::MAX_RESULTS-1] = '0;
            rem_next = rem_reg - sfcs_pkg::RES_CNT_W'(1);
        end

        if (proceed)
        begin
            for (int i = 0; i < sfcs_pkg::MAX_RESULTS; i++)
            begin
                list_next[i] = '0;
            end
            case (in_req_reg)
                sfcs_pkg::REQ_ID:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        kind_next = sfcs_pkg::KIND_ID;
                        list_next[0] = sfcs_pkg::mk(sfcs_pkg::ACT_LOW, 8'd0, 1'b0, 1'b0);
                        list_next[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, sfcs_pkg::OP_ID,
                                                    1'b0, 1'b0);
                        list_next[2] = sfcs_pkg::mk(sfcs_pkg::ACT_RECV, 8'd0, 1'b0, 1'b0);
                        list_next[3] = sfcs_pkg::mk(sfcs_pkg::ACT_HIGH, 8'd0, 1'b0, 1'b0);
                        n = sfcs_pkg::RES_CNT_W'(4);
                        phase_next = PH_ID;
                    end
                end
                sfcs_pkg::REQ_READ, sfcs_pkg::REQ_ERASE, sfcs_pkg::REQ_WRITE:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        kind_next = in_req_reg[1:0];
                        if (cnt_c == '0)
                        begin
                            list_next[0] = sfcs_pkg::mk(sfcs_pkg::ACT_REPORT, 8'd0,
                                                        1'b0, 1'b1);
                            n = sfcs_pkg::RES_CNT_W'(1);
                        end
                        else if (in_req_reg == sfcs_pkg::REQ_READ)
                        begin
                            cur_addr_next = addr_m;
                            remain_next   = cnt_c;
                            list_next[0] = sfcs_pkg::mk(sfcs_pkg::ACT_LOW, 8'd0, 1'b0, 1'b0);
                            list_next[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, sfcs_pkg::OP_READ,
                                                        1'b0, 1'b0);
                            list_next[2] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                                        8'(24'(addr_m) >> 16), 1'b0, 1'b0);
                            list_next[3] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                                        8'(24'(addr_m) >> 8), 1'b0, 1'b0);
                            list_next[4] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                                        8'(24'(addr_m)), 1'b0, 1'b0);
                            list_next[5] = sfcs_pkg::mk(sfcs_pkg::ACT_RECV, 8'd0, 1'b0, 1'b0);
                            n = sfcs_pkg::RES_CNT_W'(6);
                            phase_next = PH_READ;
                        end
                        else
                        begin
                            if (in_req_reg == sfcs_pkg::REQ_ERASE)
                            begin
                                cur_addr_next = addr_m & ~SECTOR_MASK;
                                end_addr_next = AW'(last_byte) & ~SECTOR_MASK;
                            end
                            else
                            begin
                                cur_addr_next = addr_m;
                                remain_next   = cnt_c;
                            end
                            list_next[0] = sfcs_pkg::mk(sfcs_pkg::ACT_LOW, 8'd0, 1'b0, 1'b0);
                            list_next[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                                        sfcs_pkg::OP_STATUS, 1'b0, 1'b0);
                            list_next[2] = sfcs_pkg::mk(sfcs_pkg::ACT_RECV, 8'd0, 1'b0, 1'b0);
                            list_next[3] = sfcs_pkg::mk(sfcs_pkg::ACT_HIGH, 8'd0, 1'b0, 1'b0);
                            n = sfcs_pkg::RES_CNT_W'(4);
                            poll_after_next = 1'b0;
                            phase_next = PH_POLL;
                        end
                    end
                end
                sfcs_pkg::REQ_DATA:
                begin
                    if (phase_reg == PH_DATA)
                    begin
                        list_next[0] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, in_byte_reg,
                                                    1'b0, 1'b0);
                        n = sfcs_pkg::RES_CNT_W'(1);
                        cur_addr_next = cur_inc;
                        remain_next   = rem_after;
                        if ((rem_after == '0) || ((cur_inc & PAGE_MASK) == '0))
                        begin
                            list_next[1] = sfcs_pkg::mk(sfcs_pkg::ACT_HIGH, 8'd0, 1'b0, 1'b0);
                            list_next[2] = sfcs_pkg::mk(sfcs_pkg::ACT_LOW, 8'd0, 1'b0, 1'b0);
                            list_next[3] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                                        sfcs_pkg::OP_STATUS, 1'b0, 1'b0);
                            list_next[4] = sfcs_pkg::mk(sfcs_pkg::ACT_RECV, 8'd0, 1'b0, 1'b0);
                            n = sfcs_pkg::RES_CNT_W'(5);
                            poll_after_next = 1'b1;
                            phase_next = PH_POLL;
                        end
                    end
                end
                sfcs_pkg::REQ_BYTE_IN:
                begin
                    if (phase_reg == PH_ID)
                    begin
                        list_next[0] = sfcs_pkg::mk(sfcs_pkg::ACT_REPORT, in_byte_reg,
                                                    in_byte_reg != sfcs_pkg::EXPECTED_ID, 1'b1);
                        n = sfcs_pkg::RES_CNT_W'(1);
                        phase_next = PH_IDLE;
                    end
                    else if (phase_reg == PH_READ)
                    begin
                        if (remain_reg <= 25'd1)
                        begin
                            remain_next = '0;
                            list_next[0] = sfcs_pkg::mk(sfcs_pkg::ACT_HIGH, 8'd0, 1'b0, 1'b0);
                            list_next[1] = sfcs_pkg::mk(sfcs_pkg::ACT_REPORT, in_byte_reg,
                                                        1'b0, 1'b1);
                            n = sfcs_pkg::RES_CNT_W'(2);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            remain_next   = remain_reg - 25'd1;
                            cur_addr_next = cur_inc;
                            list_next[0] = sfcs_pkg::mk(sfcs_pkg::ACT_REPORT, in_byte_reg,
                                                        1'b0, 1'b0);
                            list_next[1] = sfcs_pkg::mk(sfcs_pkg::ACT_RECV, 8'd0, 1'b0, 1'b0);
                            n = sfcs_pkg::RES_CNT_W'(2);
                        end
                    end
                    else if (phase_reg == PH_POLL)
                    begin
                        if (poll_after_reg)
                        begin
                            list_next[0] = sfcs_pkg::mk(sfcs_pkg::ACT_HIGH, 8'd0, 1'b0, 1'b0);
                            n = sfcs_pkg::RES_CNT_W'(1);
                        end
                        if (busy)
                        begin
                            list_next[n[sfcs_pkg::RES_IDX_W-1:0]] =
                                sfcs_pkg::mk(sfcs_pkg::ACT_LOW, 8'd0, 1'b0, 1'b0);
                            list_next[n[sfcs_pkg::RES_IDX_W-1:0] + 4'd1] =
                                sfcs_pkg::mk(sfcs_pkg::ACT_SEND, sfcs_pkg::OP_STATUS,
                                             1'b0, 1'b0);
                            list_next[n[sfcs_pkg::RES_IDX_W-1:0] + 4'd2] =
                                sfcs_pkg::mk(sfcs_pkg::ACT_RECV, 8'd0, 1'b0, 1'b0);
                            if (poll_after_reg)
                            begin
                                n = sfcs_pkg::RES_CNT_W'(4);
                            end
                            else
                            begin
                                list_next[3] = sfcs_pkg::mk(sfcs_pkg::ACT_HIGH, 8'd0,
                                                            1'b0, 1'b0);
                                n = sfcs_pkg::RES_CNT_W'(4);
                            end
                        end
                        else if (!poll_after_reg)
                        begin
                            list_next[0] = sfcs_pkg::mk(sfcs_pkg::ACT_LOW, 8'd0, 1'b0, 1'b0);
                            list_next[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, sfcs_pkg::OP_WREN,
                                                        1'b0, 1'b0);
                            list_next[2] = sfcs_pkg::mk(sfcs_pkg::ACT_HIGH, 8'd0, 1'b0, 1'b0);
                            list_next[3] = sfcs_pkg::mk(sfcs_pkg::ACT_LOW, 8'd0, 1'b0, 1'b0);
                            list_next[5] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, addr24[23:16],
                                                        1'b0, 1'b0);
                            list_next[6] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, addr24[15:8],
                                                        1'b0, 1'b0);
                            list_next[7] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, addr24[7:0],
                                                        1'b0, 1'b0);
                            if (kind_reg == sfcs_pkg::KIND_ERASE)
                            begin
                                list_next[4] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                                            sfcs_pkg::OP_ERASE, 1'b0, 1'b0);
                                list_next[8] = sfcs_pkg::mk(sfcs_pkg::ACT_HIGH, 8'd0,
                                                            1'b0, 1'b0);
                                list_next[9] = sfcs_pkg::mk(sfcs_pkg::ACT_LOW, 8'd0,
                                                            1'b0, 1'b0);
                                list_next[10] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                                             sfcs_pkg::OP_STATUS, 1'b0, 1'b0);
                                list_next[11] = sfcs_pkg::mk(sfcs_pkg::ACT_RECV, 8'd0,
                                                             1'b0, 1'b0);
                                n = sfcs_pkg::RES_CNT_W'(12);
                                poll_after_next = 1'b1;
                            end
                            else
                            begin
                                list_next[4] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                                            sfcs_pkg::OP_PROGRAM, 1'b0, 1'b0);
                                n = sfcs_pkg::RES_CNT_W'(8);
                                phase_next = PH_DATA;
                            end
                        end
                        else if (((kind_reg == sfcs_pkg::KIND_ERASE) &&
                                  (cur_addr_reg == end_addr_reg)) ||
                                 ((kind_reg != sfcs_pkg::KIND_ERASE) && (remain_reg == '0)))
                        begin
                            list_next[1] = sfcs_pkg::mk(sfcs_pkg::ACT_REPORT, 8'd0,
                                                        1'b0, 1'b1);
                            n = sfcs_pkg::RES_CNT_W'(2);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            if (kind_reg == sfcs_pkg::KIND_ERASE)
                            begin
                                cur_addr_next = cur_addr_reg + SECTOR_STEP;
                            end
                            list_next[1] = sfcs_pkg::mk(sfcs_pkg::ACT_LOW, 8'd0, 1'b0, 1'b0);
                            list_next[2] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                                        sfcs_pkg::OP_STATUS, 1'b0, 1'b0);
                            list_next[3] = sfcs_pkg::mk(sfcs_pkg::ACT_RECV, 8'd0, 1'b0, 1'b0);
                            list_next[4] = sfcs_pkg::mk(sfcs_pkg::ACT_HIGH, 8'd0, 1'b0, 1'b0);
                            n = sfcs_pkg::RES_CNT_W'(5);
                            poll_after_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    n = '0;
                end
            endcase
            rem_next = n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            kind_reg       <= sfcs_pkg::KIND_ID;
            cur_addr_reg   <= '0;
            remain_reg     <= '0;
            end_addr_reg   <= '0;
            poll_after_reg <= 1'b0;
            busy_bit_reg   <= 3'd1;
            in_valid_reg   <= 1'b0;
            rem_reg        <= '0;
            in_req_reg     <= '0;
            in_addr_reg    <= '0;
            in_cnt_reg     <= '0;
            in_byte_reg    <= '0;
            for (int i = 0; i < sfcs_pkg::MAX_RESULTS; i++)
            begin
                list_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            cur_addr_reg   <= cur_addr_next;
            remain_reg     <= remain_next;
            end_addr_reg   <= end_addr_next;
            poll_after_reg <= poll_after_next;
            busy_bit_reg   <= busy_bit_next;
            in_valid_reg   <= in_valid_next;
            rem_reg        <= rem_next;
            if (in_take)
            begin
                in_req_reg  <= s_tuser;
                in_addr_reg <= s_tdata[23:0];
                in_cnt_reg  <= s_tdata[48:24];
                in_byte_reg <= s_tdata[56:49];
            end
            for (int i = 0; i < sfcs_pkg::MAX_RESULTS; i++)
            begin
                list_reg[i] <= list_next[i];
            end
        end
    end

    a_data_is_write: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (kind_reg == sfcs_pkg::KIND_WRITE))
        else $error("data phase entered for an operation other than write");

    a_poll_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_POLL) |->
        ((kind_reg == sfcs_pkg::KIND_ERASE) || (kind_reg == sfcs_pkg::KIND_WRITE)))
        else $error("status poll running for an operation without a poll");

    a_erase_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_POLL) && (kind_reg == sfcs_pkg::KIND_ERASE)) |->
        (cur_addr_reg <= end_addr_reg))
        else $error("erase sector address ran past the end sector");

    a_buffer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= sfcs_pkg::RES_CNT_W'(sfcs_pkg::MAX_RESULTS))
        else $error("result buffer count exceeds its depth");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proceed) |=> (in_valid_reg && $stable(in_req_reg)))
        else $error("pending input word lost before it was processed");

endmodule

FILE: tb/sv/action_scoreboard_pkg.sv
// Scoreboard for the SPI flash command sequencer testbench: tracks the sequencer's
// phase, address and byte count, and predicts the bus actions of each accepted word.
// Depends on sfcs_pkg.
package action_scoreboard_pkg;

    import sfcs_pkg::*;

    localparam int unsigned PAGE_BYTES   = 256;
    localparam int unsigned SECTOR_BYTES = 4096;
    localparam int unsigned SPACE_BYTES  = 1 << 24;
    localparam int unsigned ADDR_MASK    = SPACE_BYTES - 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ID,
        PH_READ,
        PH_POLL,
        PH_DATA
    } phase_e;

    typedef struct packed {
        res_t word;
        logic last;
    } action_t;

    class action_scoreboard;

        phase_e      phase;
        kind_t       kind;
        int unsigned cur_addr;
        int unsigned end_addr;
        int unsigned remaining;
        bit          poll_after_cmd;
        logic [2:0]  busy_bit;
        action_t     expected_actions[$];
        action_t     burst[$];
        int          errors;

        function new();
            errors         = 0;
            phase          = PH_IDLE;
            kind           = KIND_ID;
            cur_addr       = 0;
            end_addr       = 0;
            remaining      = 0;
            poll_after_cmd = 1'b0;
            busy_bit       = 3'd1;
        endfunction

        function void set_busy_bit(logic [31:0] value);
            busy_bit = value[2:0];
        endfunction

        function void emit(act_t a, logic [7:0] v, logic s, logic d);
            action_t e;
            e.word.act  = a;
            e.word.val  = v;
            e.word.st   = s;
            e.word.done = d;
            e.last      = 1'b0;
            burst.push_back(e);
        endfunction

        function void mark(act_t a);
            emit(a, 8'h00, 1'b0, 1'b0);
        endfunction

        function void send_byte(logic [7:0] v);
            emit(ACT_SEND, v, 1'b0, 1'b0);
        endfunction

        function void send_address(int unsigned a);
            send_byte(8'(a >> 16));
            send_byte(8'(a >> 8));
            send_byte(8'(a));
        endfunction

        function void poll_before();
            mark(ACT_LOW);
            send_byte(OP_STATUS);
            mark(ACT_RECV);
            mark(ACT_HIGH);
            poll_after_cmd = 1'b0;
            phase          = PH_POLL;
        endfunction

        // The select high of a poll after a command is held back until its status arrives.
        function void poll_after();
            mark(ACT_LOW);
            send_byte(OP_STATUS);
            mark(ACT_RECV);
            poll_after_cmd = 1'b1;
            phase          = PH_POLL;
        endfunction

        function void finish_op();
            emit(ACT_REPORT, 8'h00, 1'b0, 1'b1);
            phase = PH_IDLE;
        endfunction

        // Predicts the actions of one accepted word and queues them; returns their number.
        function int note_word(req_t req, logic [23:0] addr, logic [24:0] cnt_in,
                               logic [7:0] db);
            int unsigned cnt;
            int unsigned avail;
            action_t     tail;
            bit          busy;
            burst.delete();
            cnt = cnt_in;
            case (req)
                REQ_ID:
                begin
                    if (phase == PH_IDLE)
                    begin
                        kind = KIND_ID;
                        mark(ACT_LOW);
                        send_byte(OP_ID);
                        mark(ACT_RECV);
                        mark(ACT_HIGH);
                        phase = PH_ID;
                    end
                end
                REQ_READ, REQ_ERASE, REQ_WRITE:
                begin
                    if (phase == PH_IDLE)
                    begin
                        avail = SPACE_BYTES - addr;
                        if (cnt > avail)
                            cnt = avail;
                        kind = kind_t'(req[1:0]);
                        if (cnt == 0)
                            finish_op();
                        else if (req == REQ_READ)
                        begin
                            cur_addr  = addr;
                            remaining = cnt;
                            mark(ACT_LOW);
                            send_byte(OP_READ);
                            send_address(addr);
                            mark(ACT_RECV);
                            phase = PH_READ;
                        end
                        else if (req == REQ_ERASE)
                        begin
                            cur_addr = (addr / SECTOR_BYTES) * SECTOR_BYTES;
                            end_addr = ((addr + cnt - 1) / SECTOR_BYTES) * SECTOR_BYTES;
                            poll_before();
                        end
                        else
                        begin
                            cur_addr  = addr;
                            remaining = cnt;
                            poll_before();
                        end
                    end
                end
                REQ_DATA:
                begin
                    if (phase == PH_DATA)
                    begin
                        send_byte(db);
                        cur_addr = (cur_addr + 1) & ADDR_MASK;
                        if (remaining > 0)
                            remaining--;
                        if (remaining == 0 || cur_addr % PAGE_BYTES == 0)
                        begin
                            mark(ACT_HIGH);
                            poll_after();
                        end
                    end
                end
                REQ_BYTE_IN:
                begin
                    case (phase)
                        PH_ID:
                        begin
                            emit(ACT_REPORT, db, db != EXPECTED_ID, 1'b1);
                            phase = PH_IDLE;
                        end
                        PH_READ:
                        begin
                            if (remaining <= 1)
                            begin
                                remaining = 0;
                                mark(ACT_HIGH);
                                emit(ACT_REPORT, db, 1'b0, 1'b1);
                                phase = PH_IDLE;
                            end
                            else
                            begin
                                remaining--;
                                cur_addr = (cur_addr + 1) & ADDR_MASK;
                                emit(ACT_REPORT, db, 1'b0, 1'b0);
                                mark(ACT_RECV);
                            end
                        end
                        PH_POLL:
                        begin
                            busy = db[busy_bit];
                            if (poll_after_cmd)
                                mark(ACT_HIGH);
                            if (busy)
                            begin
                                if (poll_after_cmd)
                                    poll_after();
                                else
                                    poll_before();
                            end
                            else if (!poll_after_cmd)
                            begin
                                mark(ACT_LOW);
                                send_byte(OP_WREN);
                                mark(ACT_HIGH);
                                mark(ACT_LOW);
                                if (kind == KIND_ERASE)
                                begin
                                    send_byte(OP_ERASE);
                                    send_address(cur_addr);
                                    mark(ACT_HIGH);
                                    poll_after();
                                end
                                else
                                begin
                                    send_byte(OP_PROGRAM);
                                    send_address(cur_addr);
                                    phase = PH_DATA;
                                end
                            end
                            else if (kind == KIND_ERASE)
                            begin
                                if (cur_addr == end_addr)
                                    finish_op();
                                else
                                begin
                                    cur_addr += SECTOR_BYTES;
                                    poll_before();
                                end
                            end
                            else if (remaining == 0)
                                finish_op();
                            else
                                poll_before();
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
            if (burst.size() > 0)
            begin
                tail      = burst.pop_back();
                tail.last = 1'b1;
                burst.push_back(tail);
            end
            foreach (burst[i])
                expected_actions.push_back(burst[i]);
            return burst.size();
        endfunction

        function void report(string field, logic [7:0] want_v, logic [7:0] got_v);
            errors++;
            $display("%0t: %s mismatch: expected %02h, actual %02h", $time, field,
                     want_v, got_v);
        endfunction

        function void check_action(act_t act, logic [7:0] val, logic st, logic done,
                                   logic last);
            action_t want;
            if (expected_actions.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word: expected none, actual action %0d value %02h",
                         $time, act, val);
                return;
            end
            want = expected_actions.pop_front();
            if (want.word.act !== act)
                report("bus_action", 8'(want.word.act), 8'(act));
            if (want.word.val !== val)
                report("byte_value", want.word.val, val);
            if (want.word.st !== st)
                report("op_status", 8'(want.word.st), 8'(st));
            if (want.word.done !== done)
                report("op_done", 8'(want.word.done), 8'(done));
            if (want.last !== last)
                report("last", 8'(want.last), 8'(last));
        endfunction

    endclass

endpackage

FILE: tb/sv/tb.sv
// Top-level testbench for spi_flash_command_sequencer: plays the host and the flash,
// drives directed and random request streams, and checks every bus action word.
// Depends on sfcs_pkg, action_scoreboard_pkg and the sequencer RTL.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sfcs_pkg::*;
    import action_scoreboard_pkg::*;

    localparam req_t        REQ_UNUSED    = 3'd7;
    localparam req_t        REQ_SPARE     = 3'd6;
    localparam logic [2:0]  BUSY_BIT_ADDR = 3'(4 * int'(REG_BUSY_BIT));
    localparam int          SETTLE_CYCLES = 12;
    localparam int          CYCLE_LIMIT   = 800000;
    localparam int          PHASE_WORDS   = 72;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    action_scoreboard sb = new();
    int  answered_words = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  calm = 1'b0;

    spi_flash_command_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Stretches without any idling alternate with noisy ones.
    initial
    begin
        forever
        begin
            repeat ($urandom_range(50, 400)) @(negedge clk);
            calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap();
                m_tready = (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_action(act_t'(m_tuser), m_tdata[7:0], m_tdata[8], m_tdata[9], m_tlast);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_word(req_t req, logic [23:0] addr, logic [24:0] cnt,
                             logic [7:0] db);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = req;
        s_tdata  = {7'd0, db, cnt, addr};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (sb.note_word(req, addr, cnt, db) > 0)
            answered_words++;
        @(negedge clk);
    endtask

    task automatic byte_in(logic [7:0] b);
        send_word(REQ_BYTE_IN, 24'($urandom), 25'($urandom), b);
    endtask

    task automatic write_busy_bit(logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = BUSY_BIT_ADDR;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_busy_bit(value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.expected_actions.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] status_byte(bit busy);
        logic [7:0] s;
        s = 8'($urandom);
        s[sb.busy_bit] = busy;
        return s;
    endfunction

    task automatic start_request();
        int          pick;
        int          shape;
        req_t        req;
        logic [23:0] addr;
        logic [24:0] cnt;
        pick  = $urandom_range(0, 99);
        req   = pick < 15 ? REQ_ID : pick < 45 ? REQ_READ : pick < 65 ? REQ_ERASE : REQ_WRITE;
        addr  = 24'($urandom);
        shape = $urandom_range(0, 99);
        if (shape < 5)
            cnt = '0;
        else if (shape < 17)
        begin
            addr = 24'(SPACE_BYTES - $urandom_range(1, 24));
            cnt  = 25'($urandom);
        end
        else if (req == REQ_ERASE)
            cnt = 25'($urandom_range(1, 3 * SECTOR_BYTES));
        else
        begin
            if (req == REQ_WRITE && shape < 60)
                addr[7:0] = 8'(PAGE_BYTES - $urandom_range(1, 8));
            cnt = 25'($urandom_range(1, 20));
        end
        send_word(req, addr, cnt, 8'($urandom));
    endtask

    task automatic feed_one(bit allow_noise);
        if (allow_noise && $urandom_range(0, 99) < 10)
        begin
            if (sb.phase == PH_IDLE)
                send_word(req_t'($urandom_range(4, 7)), 24'($urandom), 25'($urandom),
                          8'($urandom));
            else
                send_word(req_t'($urandom_range(0, 7)), 24'($urandom), 25'($urandom),
                          8'($urandom));
        end
        else
        begin
            case (sb.phase)
                PH_IDLE:          start_request();
                PH_ID, PH_READ:   byte_in(8'($urandom));
                PH_POLL:          byte_in(status_byte($urandom_range(0, 3) == 0));
                default:          send_word(REQ_DATA, 24'($urandom), 25'($urandom),
                                            8'($urandom));
            endcase
        end
    endtask

    task automatic random_phase(int target);
        int goal;
        goal = answered_words + target;
        while (answered_words < goal)
            feed_one(1'b1);
        while (sb.phase != PH_IDLE)
            feed_one(1'b0);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_ID;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Identify with a matching byte, then with a mismatch; a read while busy is dropped.
        send_word(REQ_ID, 24'hffffff, 25'h1ffffff, 8'hff);
        byte_in(EXPECTED_ID);
        send_word(REQ_ID, '0, '0, '0);
        send_word(REQ_READ, '0, 25'd4, '0);
        byte_in(8'h62);
        // Zero-length requests and stray words while idle.
        send_word(REQ_READ, 24'h123456, '0, 8'hff);
        send_word(REQ_ERASE, '0, '0, '0);
        send_word(REQ_WRITE, 24'hffffff, '0, '0);
        byte_in(EXPECTED_ID);
        send_word(REQ_DATA, 24'h5a5a5a, 25'h0a5a5a5, 8'h3c);
        send_word(REQ_UNUSED, 24'hffffff, 25'h1ffffff, 8'hff);
        send_word(REQ_SPARE, '0, '0, '0);
        // Requests that run past the top of the address space are cut there.
        send_word(REQ_READ, 24'hfffffe, 25'h1000000, 8'h00);
        byte_in(8'h00);
        byte_in(8'hff);
        send_word(REQ_ERASE, 24'hffffff, 25'h1ffffff, 8'h00);
        byte_in(8'h02);
        byte_in(8'hfd);
        byte_in(8'hff);
        byte_in(8'h00);
        send_word(REQ_WRITE, 24'hfffffe, 25'd3, 8'h00);
        byte_in(8'h00);
        send_word(REQ_DATA, '0, '0, 8'hff);
        send_word(REQ_DATA, 24'hffffff, 25'h1ffffff, 8'h00);
        byte_in(8'h00);
        drain();

        write_busy_bit({29'($urandom), 3'd0});
        random_phase(PHASE_WORDS);
        drain();
        write_busy_bit({29'($urandom), 3'd7});
        random_phase(PHASE_WORDS);
        drain();
        write_busy_bit(32'($urandom));
        random_phase(PHASE_WORDS);
        drain();
        write_busy_bit(32'($urandom));
        random_phase(PHASE_WORDS);
        drain();

        if (sb.errors == 0 && sb.expected_actions.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
rtl/sfcs_pkg.sv
rtl/spi_flash_command_sequencer.sv
tb/sv/action_scoreboard_pkg.sv
tb/sv/tb.sv
